>>> rtl/core/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

    // Operation codes of an input word
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes (paddr bit 2)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Field and register widths
    localparam int PIXEL_BITS      = 8;
    localparam int EDGE_BITS       = 11;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    // Register reset values
    localparam logic [CFG_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Depth of the command queue and of the result queue
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Source of the result value
    typedef enum logic [1:0] {
        SEL_CENTER   = 2'd0,
        SEL_SOBEL    = 2'd1,
        SEL_PREV_MID = 2'd2
    } sel_t;

    // Control part of a command word from front to back
    typedef struct packed {
        logic emit;
        sel_t sel;
        logic frame_end;
    } cmd_ctrl_t;

endpackage

>>> rtl/core/sobel_edge_magnitude_unit.sv
// Sobel 3x3 edge magnitude unit: config port, front end, command queue, back end.
// Throughput: one word per cycle unless clearing or a full queue stalls; results
// pass both queues, read and window stages and trail pixels by frame width + 1.
// Rate is set by the single read/write port pair of the line stores.
// Reset: asynchronous, active low; then a sweep zeroes the line stores
// with pixel_ready low (config writes still taken). Registers reset to 640x480.
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [sem_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [sem_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [sem_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready,
    // Input channel
    input  logic                                   pixel_valid,
    output logic                                   pixel_ready,
    input  logic                                   operation,
    input  logic [sem_pkg::PIXEL_BITS-1:0]         pixel_value,
    // Output channel
    output logic                                   edge_valid,
    input  logic                                   edge_ready,
    output logic [sem_pkg::EDGE_BITS-1:0]          edge_value,
    output logic                                   frame_end
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int QB       = sem_pkg::QUEUE_CNT_BITS;
    localparam int CMD_BITS = $bits(sem_pkg::cmd_ctrl_t) + sem_pkg::PIXEL_BITS + CW;
    localparam int RES_BITS = sem_pkg::EDGE_BITS + 1;

    logic [sem_pkg::CFG_WIDTH_BITS-1:0]  width_cfg_reg;
    logic [sem_pkg::CFG_HEIGHT_BITS-1:0] height_cfg_reg;
    logic [WW-1:0]                       width_eff;
    logic [HW-1:0]                       height_eff;
    logic                                cfg_write;

    logic                                accept;
    logic                                front_push;
    sem_pkg::cmd_ctrl_t                  front_ctrl;
    logic [CW-1:0]                       front_col;
    logic [sem_pkg::PIXEL_BITS-1:0]      front_px;

    logic [CMD_BITS-1:0]                 cmd_wd;
    logic [CMD_BITS-1:0]                 cmd_rd;
    logic [QB-1:0]                       cmd_count;
    logic                                cmd_pop;
    sem_pkg::cmd_ctrl_t                  back_ctrl;
    logic [CW-1:0]                       back_col;
    logic [sem_pkg::PIXEL_BITS-1:0]      back_px;

    logic                                clear_busy;
    logic                                res_push;
    logic [sem_pkg::EDGE_BITS-1:0]       res_value;
    logic                                res_frame_end;
    logic [RES_BITS-1:0]                 res_rd;
    logic [QB-1:0]                       res_count;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= sem_pkg::FRAME_WIDTH_RESET;
            height_cfg_reg <= sem_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sem_pkg::REG_FRAME_WIDTH:
                    width_cfg_reg  <= pwdata[sem_pkg::CFG_WIDTH_BITS-1:0];
                sem_pkg::REG_FRAME_HEIGHT:
                    height_cfg_reg <= pwdata[sem_pkg::CFG_HEIGHT_BITS-1:0];
                default:
                    width_cfg_reg  <= width_cfg_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (paddr[2])
            sem_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_cfg_reg);
            sem_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_cfg_reg);
            default:                   prdata = '0;
        endcase
    end

    // Frame size clamped to 1..MAX
    assign width_eff  = (width_cfg_reg == '0) ? WW'(1) :
                        (32'(width_cfg_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                        WW'(width_cfg_reg);
    assign height_eff = (height_cfg_reg == '0) ? HW'(1) :
                        (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) :
                        HW'(height_cfg_reg);

    // Input handshake
    assign pixel_ready = !clear_busy && (cmd_count < QB'(sem_pkg::QUEUE_DEPTH));
    assign accept      = pixel_valid && pixel_ready;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (operation),
        .pixel_value (pixel_value),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .push        (front_push),
        .cmd_ctrl    (front_ctrl),
        .cmd_col     (front_col),
        .cmd_px      (front_px)
    );

    // Command queue between front and back
    assign cmd_wd = {front_ctrl, front_px, front_col};

    sem_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (sem_pkg::QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (cmd_wd),
        .pop       (cmd_pop),
        .pop_data  (cmd_rd),
        .count     (cmd_count)
    );

    assign {back_ctrl, back_px, back_col} = cmd_rd;

    sem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_avail     (cmd_count != '0),
        .cmd_ctrl      (back_ctrl),
        .cmd_col       (back_col),
        .cmd_px        (back_px),
        .res_count     (res_count),
        .cmd_pop       (cmd_pop),
        .clear_busy    (clear_busy),
        .res_push      (res_push),
        .res_value     (res_value),
        .res_frame_end (res_frame_end)
    );

    // Result queue decouples the output handshake
    sem_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (sem_pkg::QUEUE_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data ({res_frame_end, res_value}),
        .pop       (edge_valid && edge_ready),
        .pop_data  (res_rd),
        .count     (res_count)
    );

    assign edge_valid = (res_count != '0);
    assign {frame_end, edge_value} = res_rd;

endmodule

>>> rtl/core/sem_fifo.sv
// Small register queue used for commands and for results.
module sem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_next;

    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/sem_front.sv
// Front end: classifies each word and tracks input and output raster positions.
module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 operation,
    input  logic [sem_pkg::PIXEL_BITS-1:0]       pixel_value,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      height_eff,
    output logic                                 push,
    output sem_pkg::cmd_ctrl_t                   cmd_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]         cmd_col,
    output logic [sem_pkg::PIXEL_BITS-1:0]       cmd_px
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [PW-1:0] pending_reg, pending_next;

    logic          in_col_last;
    logic          in_row_last;
    logic          out_col_last;
    logic          out_row_last;
    logic          is_flush;
    logic          pix_emit;
    logic          flush_go;
    logic          emit;
    logic          interior;
    logic [CW-1:0] flush_col;

    // Position compares against the clamped frame size
    assign in_col_last  = ({1'b0, in_col_reg} + (CW+1)'(1)) >= (CW+1)'(width_eff);
    assign in_row_last  = ({1'b0, in_row_reg} + (RW+1)'(1)) >= (RW+1)'(height_eff);
    assign out_col_last = ({1'b0, out_col_reg} + (CW+1)'(1)) >= (CW+1)'(width_eff);
    assign out_row_last = ({1'b0, out_row_reg} + (RW+1)'(1)) >= (RW+1)'(height_eff);

    // Classification of the incoming word
    assign is_flush  = (operation == sem_pkg::OP_FLUSH);
    assign pix_emit  = pending_reg >= (PW'(width_eff) + PW'(1));
    assign flush_go  = (pending_reg != '0);
    assign emit      = is_flush ? flush_go : pix_emit;
    assign interior  = (out_row_reg != '0) && !out_row_last && (out_col_reg != '0);
    assign flush_col = out_col_last ? '0 : out_col_reg + 1'b1;

    // Command word
    assign push               = accept && (!is_flush || flush_go);
    assign cmd_col            = is_flush ? flush_col : in_col_reg;
    assign cmd_px             = is_flush ? '0 : pixel_value;
    assign cmd_ctrl.emit      = emit;
    assign cmd_ctrl.frame_end = out_col_last && out_row_last;
    assign cmd_ctrl.sel       = out_col_last ? sem_pkg::SEL_PREV_MID :
                                interior     ? sem_pkg::SEL_SOBEL    :
                                               sem_pkg::SEL_CENTER;

    // Counter next state
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        if (push)
        begin
            if (!is_flush)
            begin
                if (in_col_last)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_last ? '0 : in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (!pix_emit)
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end
            else
            begin
                pending_next = pending_reg - 1'b1;
            end
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

endmodule

>>> rtl/core/sem_back.sv
// Back end: line stores, 3x3 window and Sobel magnitude.
module sem_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_avail,
    input  sem_pkg::cmd_ctrl_t                   cmd_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]         cmd_col,
    input  logic [sem_pkg::PIXEL_BITS-1:0]       cmd_px,
    input  logic [sem_pkg::QUEUE_CNT_BITS-1:0]   res_count,
    output logic                                 cmd_pop,
    output logic                                 clear_busy,
    output logic                                 res_push,
    output logic [sem_pkg::EDGE_BITS-1:0]        res_value,
    output logic                                 res_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PB = sem_pkg::PIXEL_BITS;
    localparam int QB = sem_pkg::QUEUE_CNT_BITS;

    // Line stores
    logic [PB-1:0] upper_mem  [MAX_WIDTH];
    logic [PB-1:0] middle_mem [MAX_WIDTH];

    // Clearing pass after reset
    logic          clearing_reg, clearing_next;
    logic [CW-1:0] clr_addr_reg, clr_addr_next;

    // Read stage
    logic               s1_valid_reg;
    sem_pkg::cmd_ctrl_t s1_ctrl_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [PB-1:0]      s1_px_reg;
    logic [PB-1:0]      rd_upper_reg;
    logic [PB-1:0]      rd_middle_reg;
    logic               byp_valid_reg;
    logic [PB-1:0]      byp_upper_reg;
    logic [PB-1:0]      byp_middle_reg;

    // Window stage
    logic [PB-1:0]      window_reg [9];
    logic [PB-1:0]      window_next [9];
    logic               s2_valid_reg;
    sem_pkg::cmd_ctrl_t s2_ctrl_reg;
    logic [PB-1:0]      s2_prev_mid_reg;

    logic          s1_emit;
    logic [QB-1:0] room_sum;
    logic [PB-1:0] top_px;
    logic [PB-1:0] mid_px;
    logic          mem_we;
    logic [CW-1:0] mem_addr;
    logic [PB-1:0] mem_upper_wd;
    logic [PB-1:0] mem_middle_wd;

    logic [PB+1:0] sum_bot;
    logic [PB+1:0] sum_top;
    logic [PB+1:0] sum_rgt;
    logic [PB+1:0] sum_lft;
    logic [PB+1:0] gx_abs;
    logic [PB+1:0] gy_abs;
    logic [sem_pkg::EDGE_BITS-1:0] sobel_mag;

    assign clear_busy = clearing_reg;

    // Pop only when the result queue has room for everything in flight
    assign s1_emit  = s1_valid_reg && s1_ctrl_reg.emit;
    assign room_sum = res_count + QB'(s1_emit) + QB'(s2_valid_reg);
    assign cmd_pop  = cmd_avail && !clearing_reg && (room_sum < QB'(sem_pkg::QUEUE_DEPTH));

    // Store data, with bypass of the write made on the read edge
    assign top_px = byp_valid_reg ? byp_upper_reg  : rd_upper_reg;
    assign mid_px = byp_valid_reg ? byp_middle_reg : rd_middle_reg;

    // Line store write port: clearing sweep or column update
    assign mem_we        = clearing_reg || s1_valid_reg;
    assign mem_addr      = clearing_reg ? clr_addr_reg : s1_col_reg;
    assign mem_upper_wd  = clearing_reg ? '0 : mid_px;
    assign mem_middle_wd = clearing_reg ? '0 : s1_px_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[mem_addr]  <= mem_upper_wd;
            middle_mem[mem_addr] <= mem_middle_wd;
        end
        rd_upper_reg  <= upper_mem[cmd_col];
        rd_middle_reg <= middle_mem[cmd_col];
    end

    // Clearing sequencer
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == CW'(MAX_WIDTH - 1))
            begin
                clearing_next = 1'b0;
                clr_addr_next = '0;
            end
        end
    end

    // Window shift: new right column from the stores and the pixel
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r*3]     = window_reg[r*3];
            window_next[r*3 + 1] = window_reg[r*3 + 1];
            window_next[r*3 + 2] = window_reg[r*3 + 2];
        end
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_next[r*3]     = window_reg[r*3 + 1];
                window_next[r*3 + 1] = window_reg[r*3 + 2];
            end
            window_next[2] = top_px;
            window_next[5] = mid_px;
            window_next[8] = s1_px_reg;
        end
    end

    // Control registers of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= cmd_pop;
            s2_valid_reg <= s1_emit;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_ctrl_reg     <= cmd_ctrl;
        s1_col_reg      <= cmd_col;
        s1_px_reg       <= cmd_px;
        byp_valid_reg   <= s1_valid_reg && (s1_col_reg == cmd_col);
        byp_upper_reg   <= mid_px;
        byp_middle_reg  <= s1_px_reg;
        s2_ctrl_reg     <= s1_ctrl_reg;
        s2_prev_mid_reg <= window_reg[5];
    end

    // Sobel L1 magnitude of the current window
    always_comb
    begin
        sum_bot = {2'b0, window_reg[6]} + {1'b0, window_reg[7], 1'b0} + {2'b0, window_reg[8]};
        sum_top = {2'b0, window_reg[0]} + {1'b0, window_reg[1], 1'b0} + {2'b0, window_reg[2]};
        sum_rgt = {2'b0, window_reg[2]} + {1'b0, window_reg[5], 1'b0} + {2'b0, window_reg[8]};
        sum_lft = {2'b0, window_reg[0]} + {1'b0, window_reg[3], 1'b0} + {2'b0, window_reg[6]};
        gx_abs  = (sum_bot >= sum_top) ? sum_bot - sum_top : sum_top - sum_bot;
        gy_abs  = (sum_rgt >= sum_lft) ? sum_rgt - sum_lft : sum_lft - sum_rgt;
        sobel_mag = {1'b0, gx_abs} + {1'b0, gy_abs};
    end

    // Result select
    always_comb
    begin
        case (s2_ctrl_reg.sel)
            sem_pkg::SEL_SOBEL:    res_value = sobel_mag;
            sem_pkg::SEL_PREV_MID: res_value = {3'b0, s2_prev_mid_reg};
            sem_pkg::SEL_CENTER:   res_value = {3'b0, window_reg[4]};
            default:               res_value = {3'b0, window_reg[4]};
        endcase
    end

    assign res_push      = s2_valid_reg;
    assign res_frame_end = s2_ctrl_reg.frame_end;

endmodule
